### hdl/sorted_table_with_age_eviction_top_assert.svh
// Assertion macros for the sorted table checker.
// Used by stawe_checker; expects clk_i and rst_ni in scope.
`ifndef SORTED_TABLE_WITH_AGE_EVICTION_TOP_ASSERT_SVH
`define SORTED_TABLE_WITH_AGE_EVICTION_TOP_ASSERT_SVH

// same-cycle implication
`define STAWE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define STAWE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### hdl/stawe_pkg.sv
// Types and constants of the sorted table with age eviction.
// No dependencies; used by stawe_mem, stawe_cmp and the top level.
package stawe_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned HOURS_W = 10;
  localparam int unsigned LIMIT_W = 22;   // 1023 * 3600 fits
  localparam int unsigned OCNT_W  = 5;    // width of reported counts
  localparam int unsigned IN_DW   = 64;
  localparam int unsigned OUT_DW  = 48;

  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_PURGE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PRG,
    ST_LOW,
    ST_OUT
  } state_e;

  typedef enum logic {
    CMP_KEY,
    CMP_AGE
  } cmp_op_e;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [ID_W-1:0]    id;
    logic [KEY_W-1:0]   key;
  } entry_t;

  typedef struct packed {
    cmp_op_e            op;
    logic [STAMP_W-1:0] lhs;
    logic [STAMP_W-1:0] rhs;
  } cmp_req_t;

endpackage

### hdl/stawe_mem.sv
// Entry store: one write port, one read port with registered read data.
// Depends on stawe_pkg for the entry layout.
module stawe_mem #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  stawe_pkg::entry_t wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output stawe_pkg::entry_t rdata_o
);

  stawe_pkg::entry_t mem_q [DEPTH];
  stawe_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/stawe_cmp.sv
// Shared compare unit: key greater-than for insert, age over limit for purge.
// Depends on stawe_pkg.
module stawe_cmp (
  input  stawe_pkg::cmp_req_t           req_i,
  input  logic [stawe_pkg::LIMIT_W-1:0] limit_i,
  output logic                          gt_o
);

  logic [stawe_pkg::STAMP_W-1:0] diff;

  // age wraps modulo 2^32
  assign diff = req_i.lhs - req_i.rhs;

  always_comb begin
    case (req_i.op)
      stawe_pkg::CMP_KEY: begin
        gt_o = req_i.lhs[stawe_pkg::KEY_W-1:0] > req_i.rhs[stawe_pkg::KEY_W-1:0];
      end
      stawe_pkg::CMP_AGE: begin
        gt_o = diff > stawe_pkg::STAMP_W'(limit_i);
      end
      default: begin
        gt_o = 1'b0;
      end
    endcase
  end

endmodule

### hdl/sorted_table_with_age_eviction_top.sv
// Top level of the sorted table with age eviction: sequencer and registers.
// Depends on stawe_pkg, stawe_mem and stawe_cmp.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tuser=req_type, tdata=id,key,now
//  m_axis    out  tvalid/tready           tuser=lowest_valid, tdata=result
//  cfg       in   cfg_we_i (no wait)      cfg_data_i=idle_limit_hours
//
// Per item, an insert moves each larger entry up one slot and a purge reads
// every occupied slot, keeping the young entries in order; a refused insert
// moves nothing. One entry per cycle through the store and shared compare unit.
// Ready only between items.
// Reset clears occupancy, the age limit and all handshake state.
// A stalled result waits in the output register; a following item is taken
// and worked on, and its result holds until the register drains.
module sorted_table_with_age_eviction_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_data_i,       // idle_limit_hours
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,     // [0] req_type
  input  logic [63:0] s_axis_tdata,     // [15:0] entry_id, [31:16] entry_key,
                                        // [63:32] now_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic        m_axis_tuser,     // [0] lowest_valid
  output logic [47:0] m_axis_tdata      // [15:0] lowest_id, [31:16] lowest_key,
                                        // [36:32] entry_count,
                                        // [41:37] removed_count,
                                        // [42] insert_refused, [47:43] zero
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  stawe_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] wr_q, wr_d;
  logic [CNT_W-1:0] drop_q, drop_d;
  logic             vld_q, vld_d;
  logic             refused_q, refused_d;
  logic [stawe_pkg::LIMIT_W-1:0] limit_q;

  logic                            req_q;
  logic [stawe_pkg::ID_W-1:0]      id_q;
  logic [stawe_pkg::KEY_W-1:0]     key_q;
  logic [stawe_pkg::STAMP_W-1:0]   now_q;

  logic        m_valid_q, m_valid_d;
  logic        m_user_q, m_user_d;
  logic [47:0] m_data_q, m_data_d;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  stawe_pkg::entry_t mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  stawe_pkg::entry_t rd_data;

  stawe_pkg::cmp_req_t cmp_req;
  logic                cmp_gt;

  stawe_pkg::entry_t new_entry;
  logic [CNT_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  pos_m2;
  logic              in_acc;
  logic              low_vld;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign new_entry = '{stamp: now_q, id: id_q, key: key_q};
  assign pos_m1    = pos_q - CNT_W'(1);
  assign pos_m2    = pos_q - CNT_W'(2);
  assign low_vld   = occ_q != '0;

  stawe_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  always_comb begin
    if (req_q == stawe_pkg::REQ_PURGE) begin
      cmp_req.op  = stawe_pkg::CMP_AGE;
      cmp_req.lhs = now_q;
      cmp_req.rhs = rd_data.stamp;
    end else begin
      cmp_req.op  = stawe_pkg::CMP_KEY;
      cmp_req.lhs = stawe_pkg::STAMP_W'(rd_data.key);
      cmp_req.rhs = stawe_pkg::STAMP_W'(key_q);
    end
  end

  stawe_cmp u_cmp (
    .req_i   (cmp_req),
    .limit_i (limit_q),
    .gt_o    (cmp_gt)
  );

  assign s_axis_tready = (state_q == stawe_pkg::ST_IDLE);

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    pos_d     = pos_q;
    wr_d      = wr_q;
    drop_d    = drop_q;
    vld_d     = vld_q;
    refused_d = refused_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_user_d  = m_user_q;
    m_data_d  = m_data_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q[AW-1:0];
    mem_wdata = rd_data;
    mem_re    = 1'b0;
    mem_raddr = pos_m1[AW-1:0];

    case (state_q)
      stawe_pkg::ST_IDLE: begin
        if (in_acc) begin
          refused_d = 1'b0;
          drop_d    = '0;
          wr_d      = '0;
          vld_d     = 1'b0;
          if (s_axis_tuser == stawe_pkg::REQ_PURGE) begin
            pos_d   = '0;
            state_d = stawe_pkg::ST_PRG;
          end else if (occ_q == CNT_W'(DEPTH)) begin
            refused_d = 1'b1;
            state_d   = stawe_pkg::ST_LOW;
          end else begin
            pos_d   = occ_q;
            state_d = stawe_pkg::ST_INS;
          end
        end
      end

      // walk down from the top; move larger keys up one slot
      stawe_pkg::ST_INS: begin
        if (vld_q) begin
          mem_we = 1'b1;
          if (cmp_gt) begin
            mem_wdata = rd_data;
            pos_d     = pos_m1;
            if (pos_q > CNT_W'(1)) begin
              mem_re    = 1'b1;
              mem_raddr = pos_m2[AW-1:0];
              vld_d     = 1'b1;
            end else begin
              vld_d = 1'b0;
            end
          end else begin
            mem_wdata = new_entry;
            occ_d     = occ_q + CNT_W'(1);
            vld_d     = 1'b0;
            state_d   = stawe_pkg::ST_LOW;
          end
        end else if (pos_q == '0) begin
          mem_we    = 1'b1;
          mem_wdata = new_entry;
          occ_d     = occ_q + CNT_W'(1);
          state_d   = stawe_pkg::ST_LOW;
        end else begin
          mem_re = 1'b1;
          vld_d  = 1'b1;
        end
      end

      // read pointer in pos_q, compaction pointer in wr_q
      stawe_pkg::ST_PRG: begin
        if (vld_q) begin
          if (cmp_gt) begin
            drop_d = drop_q + CNT_W'(1);
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wr_q[AW-1:0];
            wr_d      = wr_q + CNT_W'(1);
          end
        end
        if (pos_q < occ_q) begin
          mem_re    = 1'b1;
          mem_raddr = pos_q[AW-1:0];
          pos_d     = pos_q + CNT_W'(1);
          vld_d     = 1'b1;
        end else begin
          vld_d = 1'b0;
          if (!vld_q) begin
            occ_d   = wr_q;
            state_d = stawe_pkg::ST_LOW;
          end
        end
      end

      stawe_pkg::ST_LOW: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_d   = stawe_pkg::ST_OUT;
      end

      stawe_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = low_vld;
          m_data_d  = {5'b0,
                       refused_q,
                       stawe_pkg::OCNT_W'(drop_q),
                       stawe_pkg::OCNT_W'(occ_q),
                       low_vld ? rd_data.key : stawe_pkg::KEY_W'(0),
                       low_vld ? rd_data.id : stawe_pkg::ID_W'(0)};
          state_d   = stawe_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = stawe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= stawe_pkg::ST_IDLE;
      occ_q     <= '0;
      pos_q     <= '0;
      wr_q      <= '0;
      drop_q    <= '0;
      vld_q     <= 1'b0;
      refused_q <= 1'b0;
      m_valid_q <= 1'b0;
      limit_q   <= '0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      pos_q     <= pos_d;
      wr_q      <= wr_d;
      drop_q    <= drop_d;
      vld_q     <= vld_d;
      refused_q <= refused_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        limit_q <= stawe_pkg::LIMIT_W'(cfg_data_i) * stawe_pkg::LIMIT_W'(stawe_pkg::SEC_PER_HOUR);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= s_axis_tuser;
      id_q  <= s_axis_tdata[15:0];
      key_q <= s_axis_tdata[31:16];
      now_q <= s_axis_tdata[63:32];
    end
    m_user_q <= m_user_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### hdl/stawe_checker.sv
// Port-level checks of the sorted table, bound to the top level.
// Depends on sorted_table_with_age_eviction_top_assert.svh.
`include "sorted_table_with_age_eviction_top_assert.svh"

module stawe_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        m_axis_tuser,
  input logic [47:0] m_axis_tdata
);

  logic small_depth;
  assign small_depth = DEPTH < 32;

  `STAWE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // one item at a time: no accept right after an accept
  `STAWE_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  `STAWE_ASSERT_NOW(a_valid_vs_count, m_axis_tvalid && small_depth,
                    m_axis_tuser == (m_axis_tdata[36:32] != 5'd0))

  `STAWE_ASSERT_NOW(a_refuse_no_drop, m_axis_tvalid && m_axis_tdata[42],
                    m_axis_tdata[41:37] == 5'd0)

  `STAWE_ASSERT_NOW(a_count_bound, m_axis_tvalid && small_depth,
                    m_axis_tdata[36:32] <= 5'(DEPTH))

endmodule

bind sorted_table_with_age_eviction_top stawe_checker #(
  .DEPTH (DEPTH)
) u_stawe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tdata  (m_axis_tdata)
);
